### hdl/url_field_splitter_macros.svh
// Assertion macros for the URL field splitter.
`ifndef URL_FIELD_SPLITTER_MACROS_SVH
`define URL_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define UFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ufs_pkg.sv
// Shared constants for the URL field splitter: widths, scanner phases, codes.
`default_nettype none

package ufs_pkg;

  localparam int unsigned MAX_URL_LEN_DEF  = 1024;
  localparam int unsigned DEFAULT_PORT_RST = 80;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned START_W   = 10;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned FLAG_W    = 10;

  // scanner phases
  localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SCHEME = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SLASH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOST   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PORT   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PATH   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_QUERY  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OC_OK      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OC_BAD     = 2'd1;
  localparam logic [OUTCOME_W-1:0] OC_TOOLONG = 2'd2;

  // bit positions in the seen-flags vector
  localparam int unsigned SF_SCH_B = 0;
  localparam int unsigned SF_SCH_E = 1;
  localparam int unsigned SF_HST_B = 2;
  localparam int unsigned SF_HST_E = 3;
  localparam int unsigned SF_PRT_B = 4;
  localparam int unsigned SF_PRT_E = 5;
  localparam int unsigned SF_PTH_B = 6;
  localparam int unsigned SF_PTH_E = 7;
  localparam int unsigned SF_QRY_B = 8;
  localparam int unsigned SF_QRY_E = 9;

  // bit positions in the presence mask
  localparam int unsigned PM_SCHEME = 0;
  localparam int unsigned PM_HOST   = 1;
  localparam int unsigned PM_PATH   = 2;
  localparam int unsigned PM_QUERY  = 3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

### hdl/url_field_splitter.sv
// URL field splitter: byte-serial URL scanner with registered input and result stages.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | in_char_in, in_last
//  out     | output    | out_valid / out_ready| outcome, field starts/lengths, port, mask
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (default port)
//
// One byte per cycle sustained, but a last byte waits while a result is held; a byte
// is held in the input register, the scanner consumes it, and on the last byte the result
// register loads as the scanner clears. out_valid thus follows the input and result registers.
// Reset (rst_n low, synchronous) clears the scanner, both valid bits and sets the
// default port to 80. A stalled result holds only the last byte of the next URL;
// other bytes keep flowing.
`default_nettype none
`include "url_field_splitter_macros.svh"

module url_field_splitter
  import ufs_pkg::*;
#(
  parameter int unsigned MAX_URL_LEN = MAX_URL_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAR_W-1:0]    in_char_in,
  input  wire logic                 in_last,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUTCOME_W-1:0]      out_outcome,
  output logic [START_W-1:0]        out_scheme_start,
  output logic [LEN_W-1:0]          out_scheme_len,
  output logic [START_W-1:0]        out_host_start,
  output logic [LEN_W-1:0]          out_host_len,
  output logic [PORT_W-1:0]         out_port_num,
  output logic [START_W-1:0]        out_path_start,
  output logic [LEN_W-1:0]          out_path_len,
  output logic [START_W-1:0]        out_query_start,
  output logic [LEN_W-1:0]          out_query_len,
  output logic [MASK_W-1:0]         out_present_mask,

  input  wire logic                 cfg_wr_en,
  input  wire logic [PORT_W-1:0]    cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(MAX_URL_LEN + 1);
  localparam int unsigned EXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_LEN);

  // input register
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              out_free;

  // scanner state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [POS_W-1:0]   sch_b_r, sch_b_nxt, sch_e_r, sch_e_nxt;
  logic [POS_W-1:0]   hst_b_r, hst_b_nxt, hst_e_r, hst_e_nxt;
  logic [POS_W-1:0]   pth_b_r, pth_b_nxt, pth_e_r, pth_e_nxt;
  logic [POS_W-1:0]   qry_b_r, qry_b_nxt, qry_e_r, qry_e_nxt;
  logic [PORT_W-1:0]  port_acc_r, port_acc_nxt;
  logic [FLAG_W-1:0]  flags_r, flags_nxt;
  logic               bad_r, bad_nxt;
  logic               long_r, long_nxt;
  logic [PORT_W-1:0]  dflt_port_r;

  logic [PORT_W+3:0]  port_mul;

  // result register
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;
  logic [START_W-1:0]   out_ss_r, out_ss_nxt, out_hs_r, out_hs_nxt;
  logic [START_W-1:0]   out_ps_r, out_ps_nxt, out_qs_r, out_qs_nxt;
  logic [LEN_W-1:0]     out_sl_r, out_sl_nxt, out_hl_r, out_hl_nxt;
  logic [LEN_W-1:0]     out_pl_r, out_pl_nxt, out_ql_r, out_ql_nxt;
  logic [PORT_W-1:0]    out_port_r, out_port_nxt;
  logic [MASK_W-1:0]    out_mask_r, out_mask_nxt;

  logic [POS_W-1:0] pth_end_sel, qry_end_sel;
  logic [EXT_W-1:0] sl_x, hl_x, pl_x, ql_x;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_port_r <= PORT_W'(DEFAULT_PORT_RST);
    end else if (cfg_wr_en) begin
      dflt_port_r <= cfg_wr_data;
    end
  end

  assign port_mul = ({4'd0, port_acc_r} << 3) + ({4'd0, port_acc_r} << 1)
                    + {16'd0, s1_char_r[3:0]};

  // per-byte scanner update
  always_comb begin
    phase_nxt    = phase_r;
    byte_pos_nxt = byte_pos_r;
    sch_b_nxt    = sch_b_r;
    sch_e_nxt    = sch_e_r;
    hst_b_nxt    = hst_b_r;
    hst_e_nxt    = hst_e_r;
    pth_b_nxt    = pth_b_r;
    pth_e_nxt    = pth_e_r;
    qry_b_nxt    = qry_b_r;
    qry_e_nxt    = qry_e_r;
    port_acc_nxt = port_acc_r;
    flags_nxt    = flags_r;
    bad_nxt      = bad_r;
    long_nxt     = long_r;
    if (s1_valid_r) begin
      if (byte_pos_r >= POS_MAX) begin
        long_nxt = 1'b1;
      end else begin
        byte_pos_nxt = byte_pos_r + 1'b1;
        if (phase_r != PH_DONE) begin
          if (s1_char_r == CH_NUL) begin
            phase_nxt = PH_DONE;
          end else begin
            unique case (phase_r)
              PH_START: begin
                if (is_ws(s1_char_r)) begin
                end else if (is_letter(s1_char_r)) begin
                  sch_b_nxt = byte_pos_r;
                  flags_nxt[SF_SCH_B] = 1'b1;
                  phase_nxt = PH_SCHEME;
                end else if (s1_char_r == CH_SLASH) begin
                  pth_b_nxt = byte_pos_r;
                  flags_nxt[SF_PTH_B] = 1'b1;
                  phase_nxt = PH_PATH;
                end else begin
                  bad_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_SCHEME: begin
                if (is_letter(s1_char_r)) begin
                end else if (s1_char_r == CH_COLON) begin
                  sch_e_nxt = byte_pos_r;
                  flags_nxt[SF_SCH_E] = 1'b1;
                  phase_nxt = PH_SLASH;
                end else begin
                  bad_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_SLASH: begin
                if (s1_char_r == CH_SLASH) begin
                end else if (is_letter(s1_char_r)) begin
                  hst_b_nxt = byte_pos_r;
                  flags_nxt[SF_HST_B] = 1'b1;
                  phase_nxt = PH_HOST;
                end else begin
                  bad_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_HOST: begin
                if (is_letter(s1_char_r) || is_digit(s1_char_r) ||
                    s1_char_r == CH_DOT || s1_char_r == CH_DASH) begin
                end else if (s1_char_r == CH_COLON) begin
                  hst_e_nxt = byte_pos_r;
                  flags_nxt[SF_HST_E] = 1'b1;
                  flags_nxt[SF_PRT_B] = 1'b1;
                  port_acc_nxt = '0;
                  phase_nxt = PH_PORT;
                end else if (s1_char_r == CH_SLASH) begin
                  hst_e_nxt = byte_pos_r;
                  pth_b_nxt = byte_pos_r;
                  flags_nxt[SF_HST_E] = 1'b1;
                  flags_nxt[SF_PTH_B] = 1'b1;
                  phase_nxt = PH_PATH;
                end else begin
                  bad_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_PORT: begin
                if (is_digit(s1_char_r)) begin
                  port_acc_nxt = (port_mul > 20'd65535) ? {PORT_W{1'b1}}
                                                        : port_mul[PORT_W-1:0];
                end else if (s1_char_r == CH_SLASH) begin
                  pth_b_nxt = byte_pos_r;
                  flags_nxt[SF_PRT_E] = 1'b1;
                  flags_nxt[SF_PTH_B] = 1'b1;
                  phase_nxt = PH_PATH;
                end else if (is_ws(s1_char_r)) begin
                  flags_nxt[SF_PRT_E] = 1'b1;
                  phase_nxt = PH_DONE;
                end else begin
                  bad_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_PATH: begin
                if (s1_char_r == CH_QMARK) begin
                  pth_e_nxt = byte_pos_r;
                  qry_b_nxt = byte_pos_r + 1'b1;
                  flags_nxt[SF_PTH_E] = 1'b1;
                  flags_nxt[SF_QRY_B] = 1'b1;
                  phase_nxt = PH_QUERY;
                end else if (s1_char_r == CH_HASH || is_ws(s1_char_r)) begin
                  pth_e_nxt = byte_pos_r;
                  flags_nxt[SF_PTH_E] = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_QUERY: begin
                if (s1_char_r == CH_HASH || is_ws(s1_char_r)) begin
                  qry_e_nxt = byte_pos_r;
                  flags_nxt[SF_QRY_E] = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_DONE: begin
              end
            endcase
          end
        end
      end
    end
  end

  // result fields from the state after the last byte; open path/query end at byte count
  assign pth_end_sel = flags_nxt[SF_PTH_E] ? pth_e_nxt : byte_pos_nxt;
  assign qry_end_sel = flags_nxt[SF_QRY_E] ? qry_e_nxt : byte_pos_nxt;
  assign sl_x = EXT_W'(sch_e_nxt) - EXT_W'(sch_b_nxt);
  assign hl_x = EXT_W'(hst_e_nxt) - EXT_W'(hst_b_nxt);
  assign pl_x = EXT_W'(pth_end_sel) - EXT_W'(pth_b_nxt);
  assign ql_x = (qry_end_sel >= qry_b_nxt) ? EXT_W'(qry_end_sel) - EXT_W'(qry_b_nxt) : '0;

  always_comb begin
    priority if (long_nxt) begin
      out_outcome_nxt = OC_TOOLONG;
    end else if (bad_nxt ||
                 (flags_nxt[SF_SCH_B] && !flags_nxt[SF_SCH_E]) ||
                 (flags_nxt[SF_HST_B] && !flags_nxt[SF_HST_E]) ||
                 (flags_nxt[SF_PRT_B] && !flags_nxt[SF_PRT_E])) begin
      out_outcome_nxt = OC_BAD;
    end else begin
      out_outcome_nxt = OC_OK;
    end
    out_ss_nxt   = '0;
    out_sl_nxt   = '0;
    out_hs_nxt   = '0;
    out_hl_nxt   = '0;
    out_ps_nxt   = '0;
    out_pl_nxt   = '0;
    out_qs_nxt   = '0;
    out_ql_nxt   = '0;
    out_port_nxt = '0;
    out_mask_nxt = '0;
    if (out_outcome_nxt == OC_OK) begin
      out_port_nxt = flags_nxt[SF_PRT_B] ? port_acc_nxt : dflt_port_r;
      if (flags_nxt[SF_SCH_B]) begin
        out_mask_nxt[PM_SCHEME] = 1'b1;
        out_ss_nxt = START_W'(EXT_W'(sch_b_nxt));
        out_sl_nxt = sl_x[LEN_W-1:0];
      end
      if (flags_nxt[SF_HST_B]) begin
        out_mask_nxt[PM_HOST] = 1'b1;
        out_hs_nxt = START_W'(EXT_W'(hst_b_nxt));
        out_hl_nxt = hl_x[LEN_W-1:0];
      end
      if (flags_nxt[SF_PTH_B]) begin
        out_mask_nxt[PM_PATH] = 1'b1;
        out_ps_nxt = START_W'(EXT_W'(pth_b_nxt));
        out_pl_nxt = pl_x[LEN_W-1:0];
      end
      if (flags_nxt[SF_QRY_B]) begin
        out_mask_nxt[PM_QUERY] = 1'b1;
        out_qs_nxt = START_W'(EXT_W'(qry_b_nxt));
        out_ql_nxt = ql_x[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_last_r)) begin
      phase_r    <= PH_START;
      byte_pos_r <= '0;
      sch_b_r    <= '0;
      sch_e_r    <= '0;
      hst_b_r    <= '0;
      hst_e_r    <= '0;
      pth_b_r    <= '0;
      pth_e_r    <= '0;
      qry_b_r    <= '0;
      qry_e_r    <= '0;
      port_acc_r <= '0;
      flags_r    <= '0;
      bad_r      <= 1'b0;
      long_r     <= 1'b0;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      sch_b_r    <= sch_b_nxt;
      sch_e_r    <= sch_e_nxt;
      hst_b_r    <= hst_b_nxt;
      hst_e_r    <= hst_e_nxt;
      pth_b_r    <= pth_b_nxt;
      pth_e_r    <= pth_e_nxt;
      qry_b_r    <= qry_b_nxt;
      qry_e_r    <= qry_e_nxt;
      port_acc_r <= port_acc_nxt;
      flags_r    <= flags_nxt;
      bad_r      <= bad_nxt;
      long_r     <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_outcome_r <= out_outcome_nxt;
      out_ss_r      <= out_ss_nxt;
      out_sl_r      <= out_sl_nxt;
      out_hs_r      <= out_hs_nxt;
      out_hl_r      <= out_hl_nxt;
      out_ps_r      <= out_ps_nxt;
      out_pl_r      <= out_pl_nxt;
      out_qs_r      <= out_qs_nxt;
      out_ql_r      <= out_ql_nxt;
      out_port_r    <= out_port_nxt;
      out_mask_r    <= out_mask_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_scheme_start = out_ss_r;
  assign out_scheme_len   = out_sl_r;
  assign out_host_start   = out_hs_r;
  assign out_host_len     = out_hl_r;
  assign out_port_num     = out_port_r;
  assign out_path_start   = out_ps_r;
  assign out_path_len     = out_pl_r;
  assign out_query_start  = out_qs_r;
  assign out_query_len    = out_ql_r;
  assign out_present_mask = out_mask_r;

  `UFS_ASSERT_NOW(a_fail_zeroed, out_valid_r && out_outcome_r != OC_OK, out_mask_r == '0 && out_port_r == '0, "failed result carries nonzero fields")
  `UFS_ASSERT_NOW(a_pos_bound, 1'b1, byte_pos_r <= POS_MAX, "byte position beyond maximum length")
  `UFS_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_r, byte_pos_r == '0 && flags_r == '0, "scanner not cleared after last byte")
  `UFS_ASSERT_NOW(a_query_needs_path, out_valid_r && out_mask_r[PM_QUERY], out_mask_r[PM_PATH], "query reported without path")

endmodule

`default_nettype wire

### tb/url_field_splitter_tb.sv
// Self-checking testbench for url_field_splitter: directed and random URLs, predicted fields.
`timescale 1ns / 1ps

module url_field_splitter_tb
  import ufs_pkg::*;
();

  localparam int unsigned MAX_LEN     = MAX_URL_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 40;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned RAND_BYTES  = 85;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] DIGIT0 = 8'h30;
  localparam logic [CHAR_W-1:0] LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] UC_A   = 8'h41;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } byte_xfer_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [START_W-1:0]   scheme_start;
    logic [LEN_W-1:0]     scheme_len;
    logic [START_W-1:0]   host_off;
    logic [LEN_W-1:0]     host_len;
    logic [PORT_W-1:0]    port_num;
    logic [START_W-1:0]   path_off;
    logic [LEN_W-1:0]     path_len;
    logic [START_W-1:0]   query_off;
    logic [LEN_W-1:0]     query_len;
    logic [MASK_W-1:0]    present_mask;
  } url_fields_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic              in_last = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [START_W-1:0]   out_scheme_start;
  logic [LEN_W-1:0]     out_scheme_len;
  logic [START_W-1:0]   out_host_start;
  logic [LEN_W-1:0]     out_host_len;
  logic [PORT_W-1:0]    out_port_num;
  logic [START_W-1:0]   out_path_start;
  logic [LEN_W-1:0]     out_path_len;
  logic [START_W-1:0]   out_query_start;
  logic [LEN_W-1:0]     out_query_len;
  logic [MASK_W-1:0]    out_present_mask;

  logic              cfg_wr_en = 1'b0;
  logic [PORT_W-1:0] cfg_wr_data = '0;

  url_field_splitter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_scheme_start (out_scheme_start),
    .out_scheme_len   (out_scheme_len),
    .out_host_start   (out_host_start),
    .out_host_len     (out_host_len),
    .out_port_num     (out_port_num),
    .out_path_start   (out_path_start),
    .out_path_len     (out_path_len),
    .out_query_start  (out_query_start),
    .out_query_len    (out_query_len),
    .out_present_mask (out_present_mask),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  byte_xfer_t    pending_bytes[$];
  url_fields_t   url_fields_due[$];
  logic [CHAR_W-1:0] url_buf[$];

  int unsigned send_gap_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // scanner image kept by the testbench
  logic [PHASE_W-1:0] scan_ph;
  logic [LEN_W-1:0]   pos_cnt;
  logic [LEN_W-1:0]   sch_b, sch_e, hst_b, hst_e, pth_b, pth_e, qry_b, qry_e;
  int unsigned        port_acc;
  logic [FLAG_W-1:0]  seen;
  logic               bad_url, long_url;
  logic [PORT_W-1:0]  port_dflt;

  function automatic logic ws_byte(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_TAB + 8'd4);
  endfunction

  function automatic logic alpha_byte(input logic [CHAR_W-1:0] c);
    return ((c | 8'h20) >= LC_A) && ((c | 8'h20) <= LC_Z);
  endfunction

  function automatic logic digit_byte(input logic [CHAR_W-1:0] c);
    return (c >= DIGIT0) && (c <= DIGIT0 + 8'd9);
  endfunction

  function automatic void clear_scanner();
    scan_ph  = PH_START;
    pos_cnt  = '0;
    sch_b = '0; sch_e = '0; hst_b = '0; hst_e = '0;
    pth_b = '0; pth_e = '0; qry_b = '0; qry_e = '0;
    port_acc = 0;
    seen     = '0;
    bad_url  = 1'b0;
    long_url = 1'b0;
  endfunction

  function automatic void mark_bad();
    bad_url = 1'b1;
    scan_ph = PH_DONE;
  endfunction

  // advance the scanner by one byte; on the last byte queue the fields it yields
  function automatic void scan_url_byte(input logic [CHAR_W-1:0] c, input logic fin);
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] e;
    url_fields_t      r;
    p = pos_cnt;
    if (p >= MAX_LEN) begin
      long_url = 1'b1;
    end else begin
      pos_cnt = p + 1'b1;
      if (scan_ph != PH_DONE) begin
        if (c == CH_NUL) begin
          scan_ph = PH_DONE;
        end else begin
          case (scan_ph)
            PH_START: begin
              if (alpha_byte(c)) begin
                sch_b = p; seen[SF_SCH_B] = 1'b1; scan_ph = PH_SCHEME;
              end else if (c == CH_SLASH) begin
                pth_b = p; seen[SF_PTH_B] = 1'b1; scan_ph = PH_PATH;
              end else if (!ws_byte(c)) begin
                mark_bad();
              end
            end
            PH_SCHEME: begin
              if (c == CH_COLON) begin
                sch_e = p; seen[SF_SCH_E] = 1'b1; scan_ph = PH_SLASH;
              end else if (!alpha_byte(c)) begin
                mark_bad();
              end
            end
            PH_SLASH: begin
              if (alpha_byte(c)) begin
                hst_b = p; seen[SF_HST_B] = 1'b1; scan_ph = PH_HOST;
              end else if (c != CH_SLASH) begin
                mark_bad();
              end
            end
            PH_HOST: begin
              if (c == CH_COLON) begin
                hst_e = p; seen[SF_HST_E] = 1'b1; seen[SF_PRT_B] = 1'b1;
                port_acc = 0; scan_ph = PH_PORT;
              end else if (c == CH_SLASH) begin
                hst_e = p; pth_b = p;
                seen[SF_HST_E] = 1'b1; seen[SF_PTH_B] = 1'b1; scan_ph = PH_PATH;
              end else if (!(alpha_byte(c) || digit_byte(c) || c == CH_DOT || c == CH_DASH)) begin
                mark_bad();
              end
            end
            PH_PORT: begin
              if (digit_byte(c)) begin
                port_acc = port_acc * 10 + int'(c - DIGIT0);
                if (port_acc > 65535) port_acc = 65535;
              end else if (c == CH_SLASH) begin
                pth_b = p; seen[SF_PRT_E] = 1'b1; seen[SF_PTH_B] = 1'b1; scan_ph = PH_PATH;
              end else if (ws_byte(c)) begin
                seen[SF_PRT_E] = 1'b1; scan_ph = PH_DONE;
              end else begin
                mark_bad();
              end
            end
            PH_PATH: begin
              if (c == CH_QMARK) begin
                pth_e = p; qry_b = p + 1'b1;
                seen[SF_PTH_E] = 1'b1; seen[SF_QRY_B] = 1'b1; scan_ph = PH_QUERY;
              end else if (c == CH_HASH || ws_byte(c)) begin
                pth_e = p; seen[SF_PTH_E] = 1'b1; scan_ph = PH_DONE;
              end
            end
            PH_QUERY: begin
              if (c == CH_HASH || ws_byte(c)) begin
                qry_e = p; seen[SF_QRY_E] = 1'b1; scan_ph = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (fin) begin
      r = '0;
      if (long_url) begin
        r.outcome = OC_TOOLONG;
      end else if (bad_url || (seen[SF_SCH_B] && !seen[SF_SCH_E]) ||
                   (seen[SF_HST_B] && !seen[SF_HST_E]) ||
                   (seen[SF_PRT_B] && !seen[SF_PRT_E])) begin
        r.outcome = OC_BAD;
      end else begin
        r.outcome  = OC_OK;
        r.port_num = seen[SF_PRT_B] ? port_acc[PORT_W-1:0] : port_dflt;
        if (seen[SF_SCH_B]) begin
          r.present_mask[PM_SCHEME] = 1'b1;
          r.scheme_start = sch_b[START_W-1:0];
          r.scheme_len   = sch_e - sch_b;
        end
        if (seen[SF_HST_B]) begin
          r.present_mask[PM_HOST] = 1'b1;
          r.host_off = hst_b[START_W-1:0];
          r.host_len = hst_e - hst_b;
        end
        if (seen[SF_PTH_B]) begin
          // an open path runs to the total byte count
          e = seen[SF_PTH_E] ? pth_e : pos_cnt;
          r.present_mask[PM_PATH] = 1'b1;
          r.path_off = pth_b[START_W-1:0];
          r.path_len = e - pth_b;
        end
        if (seen[SF_QRY_B]) begin
          e = seen[SF_QRY_E] ? qry_e : pos_cnt;
          r.present_mask[PM_QUERY] = 1'b1;
          r.query_off = qry_b[START_W-1:0];
          r.query_len = (e >= qry_b) ? e - qry_b : '0;
        end
      end
      url_fields_due.push_back(r);
      clear_scanner();
    end
  endfunction

  // ---- stimulus helpers
  function automatic logic [CHAR_W-1:0] ws_char();
    int unsigned v;
    v = $urandom_range(5);
    return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
  endfunction

  function automatic logic [CHAR_W-1:0] letter_char();
    return 8'($urandom_range(25)) + ($urandom_range(1) ? LC_A : UC_A);
  endfunction

  function automatic logic [CHAR_W-1:0] host_char();
    int unsigned v;
    v = $urandom_range(9);
    if (v < 6) return letter_char();
    if (v < 8) return DIGIT0 + 8'($urandom_range(9));
    return (v == 8) ? CH_DOT : CH_DASH;
  endfunction

  function automatic logic [CHAR_W-1:0] path_char();
    logic [CHAR_W-1:0] c;
    do c = 8'($urandom_range(126, 33));
    while (c == CH_QMARK || c == CH_HASH);
    return c;
  endfunction

  function automatic void flush_url();
    foreach (url_buf[i])
      pending_bytes.push_back('{ch: url_buf[i], fin: (i == url_buf.size() - 1)});
    url_buf.delete();
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
  endfunction

  // mostly well-formed URLs with random content, plus noise and broken ones
  function automatic void gen_url();
    int unsigned sel;
    bit want_path;
    want_path = 1'b1;
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) url_buf.push_back(ws_char());
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(6, 1)) url_buf.push_back(8'($urandom_range(255)));
      want_path = 1'b0;
    end else if (sel < 80) begin
      repeat ($urandom_range(5, 1)) url_buf.push_back(letter_char());
      if ($urandom_range(19) != 0) url_buf.push_back(CH_COLON);
      repeat ($urandom_range(3)) url_buf.push_back(CH_SLASH);
      url_buf.push_back(letter_char());
      repeat ($urandom_range(7)) url_buf.push_back(host_char());
      sel = $urandom_range(9);
      if (sel < 4) begin
        url_buf.push_back(CH_COLON);
        repeat ($urandom_range(6)) url_buf.push_back(DIGIT0 + 8'($urandom_range(9)));
        sel = $urandom_range(9);
        if (sel >= 6) begin
          want_path = 1'b0;
          if (sel < 9) url_buf.push_back(ws_char());
        end
      end else if (sel == 9) begin
        want_path = 1'b0;
      end
    end
    if (want_path) begin
      url_buf.push_back(CH_SLASH);
      repeat ($urandom_range(8)) url_buf.push_back(path_char());
      if ($urandom_range(4) < 2) begin
        url_buf.push_back(CH_QMARK);
        repeat ($urandom_range(6)) url_buf.push_back(path_char());
      end
      sel = $urandom_range(9);
      if (sel < 3) url_buf.push_back(CH_HASH);
      else if (sel < 5) url_buf.push_back(ws_char());
      if (sel < 5) repeat ($urandom_range(4)) url_buf.push_back(path_char());
    end
    sel = $urandom_range(99);
    if (sel < 8) url_buf.insert($urandom_range(url_buf.size()), CH_NUL);
    else if (sel < 16) url_buf[$urandom_range(url_buf.size() - 1)] = 8'($urandom_range(255));
    flush_url();
  endfunction

  function automatic void gen_long(input int unsigned n, input bit qmark_last);
    url_buf.push_back(CH_SLASH);
    while (url_buf.size() < n - 1) url_buf.push_back(path_char());
    url_buf.push_back(qmark_last ? CH_QMARK : path_char());
    flush_url();
  endfunction

  // ---- checking
  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("%0t tb: mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || url_fields_due.size() != 0);
    // let the result register settle before touching the config register
    repeat (4) @(posedge clk);
  endtask

  // ---- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_url_byte(in_char_in, in_last);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid   <= 1'b1;
          in_char_in <= pending_bytes[0].ch;
          in_last    <= pending_bytes[0].fin;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor
  always @(posedge clk) begin
    url_fields_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (url_fields_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = url_fields_due.pop_front();
          check_field("outcome",      out_outcome,      want.outcome);
          check_field("scheme_start", out_scheme_start, want.scheme_start);
          check_field("scheme_len",   out_scheme_len,   want.scheme_len);
          check_field("host_off",     out_host_start,   want.host_off);
          check_field("host_len",     out_host_len,     want.host_len);
          check_field("port_num",     out_port_num,     want.port_num);
          check_field("path_off",     out_path_start,   want.path_off);
          check_field("path_len",     out_path_len,     want.path_len);
          check_field("query_off",    out_query_start,  want.query_off);
          check_field("query_len",    out_query_len,    want.query_len);
          check_field("present_mask", out_present_mask, want.present_mask);
        end
      end
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- phases: reset default port, then 0, max and random values
  initial begin
    int unsigned gap_plan[PHASES];
    int unsigned stall_plan[PHASES];
    int unsigned goal;
    logic [PORT_W-1:0] port_val;
    gap_plan   = '{0, 48, 0, 13, 0};
    stall_plan = '{0, 0, 48, 13, 0};
    clear_scanner();
    port_dflt = PORT_W'(DEFAULT_PORT_RST);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1:       port_val = '0;
          2:       port_val = '1;
          default: port_val = PORT_W'($urandom_range(65535));
        endcase
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= port_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        port_dflt = port_val;
      end
      send_gap_pct    = gap_plan[ph];
      ready_stall_pct = stall_plan[ph];
      if (ph == 0) begin
        // port saturation, query then fragment
        add_text("a:b:99999/?x#");
        flush_url();
        // zero byte stops the scan, open path counts the bytes after it
        url_buf.push_back(CH_SLASH);
        url_buf.push_back(CH_NUL);
        url_buf.push_back(8'hFF);
        flush_url();
        // leading white space, empty port ended by white space
        add_text(" a:b:");
        url_buf.push_back(CH_TAB);
        flush_url();
        add_text("?");
        flush_url();
      end else begin
        goal = pending_bytes.size() + RAND_BYTES;
        while (pending_bytes.size() < goal) gen_url();
        if (ph == PHASES - 1) begin
          // one URL over the length limit
          gen_long(MAX_LEN + 1, 1'b0);
          repeat (10) gen_url();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
